// ----- design/tlmsc_pkg.sv -----
package tlmsc_pkg;

   localparam int unsigned WidthA = 17;
   localparam int unsigned WidthB = 19;
   localparam int unsigned WidthC = 23;
   localparam int unsigned KeyBits = 8;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [WidthA-1:0] TapsA = 17'h0EF75;
   localparam logic [WidthB-1:0] TapsB = 19'h58C2F;
   localparam logic [WidthC-1:0] TapsC = 23'h739583;

   localparam logic [WidthA-1:0] SeedAReset = 17'h03130;
   localparam logic [WidthB-1:0] SeedBReset = 19'h21999;
   localparam logic [WidthC-1:0] SeedCReset = 23'h66C6A6;

   typedef enum logic [1:0] {
      REG_SEED_A = 2'd0,
      REG_SEED_B = 2'd1,
      REG_SEED_C = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WidthA-1:0] seed_a;
      logic [WidthB-1:0] seed_b;
      logic [WidthC-1:0] seed_c;
   } seed_type;

endpackage

// ----- design/tlmsc_csr.sv -----
module tlmsc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tlmsc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [tlmsc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [tlmsc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output tlmsc_pkg::seed_type                   seeds
);

   tlmsc_pkg::seed_type seeds_ff;
   tlmsc_pkg::seed_type seeds_in;
   tlmsc_pkg::reg_index_type index;
   logic write_en;

   assign index = tlmsc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign seeds = seeds_ff;

   always_comb begin
      seeds_in = seeds_ff;
      if (write_en) begin
         unique case (index)
            tlmsc_pkg::REG_SEED_A: seeds_in.seed_a = csr_pwdata[tlmsc_pkg::WidthA-1:0];
            tlmsc_pkg::REG_SEED_B: seeds_in.seed_b = csr_pwdata[tlmsc_pkg::WidthB-1:0];
            tlmsc_pkg::REG_SEED_C: seeds_in.seed_c = csr_pwdata[tlmsc_pkg::WidthC-1:0];
            default: seeds_in = seeds_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         tlmsc_pkg::REG_SEED_A: csr_prdata = {
            {(tlmsc_pkg::CsrDataWidth-tlmsc_pkg::WidthA){1'b0}}, seeds_ff.seed_a};
         tlmsc_pkg::REG_SEED_B: csr_prdata = {
            {(tlmsc_pkg::CsrDataWidth-tlmsc_pkg::WidthB){1'b0}}, seeds_ff.seed_b};
         tlmsc_pkg::REG_SEED_C: csr_prdata = {
            {(tlmsc_pkg::CsrDataWidth-tlmsc_pkg::WidthC){1'b0}}, seeds_ff.seed_c};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff.seed_a <= tlmsc_pkg::SeedAReset;
         seeds_ff.seed_b <= tlmsc_pkg::SeedBReset;
         seeds_ff.seed_c <= tlmsc_pkg::SeedCReset;
      end else begin
         seeds_ff <= seeds_in;
      end
   end

endmodule

// ----- design/tlmsc_keygen.sv -----
module tlmsc_keygen (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               restart,
   input  tlmsc_pkg::seed_type                seeds,
   output logic [tlmsc_pkg::KeyBits-1:0]      key_byte
);

   logic [tlmsc_pkg::WidthA-1:0] shift_a_ff, shift_a_in;
   logic [tlmsc_pkg::WidthB-1:0] shift_b_ff, shift_b_in;
   logic [tlmsc_pkg::WidthC-1:0] shift_c_ff, shift_c_in;

   // Eight register steps per byte; each keystream bit is the majority of
   // the three low bits seen before that step.
   always_comb begin
      logic [tlmsc_pkg::WidthA-1:0] a;
      logic [tlmsc_pkg::WidthB-1:0] b;
      logic [tlmsc_pkg::WidthC-1:0] c;
      a = restart ? seeds.seed_a : shift_a_ff;
      b = restart ? seeds.seed_b : shift_b_ff;
      c = restart ? seeds.seed_c : shift_c_ff;
      key_byte = '0;
      for (int i = 0; i < tlmsc_pkg::KeyBits; i++) begin
         key_byte[i] = (a[0] & b[0]) | (a[0] & c[0]) | (b[0] & c[0]);
         a = {^(a & tlmsc_pkg::TapsA), a[tlmsc_pkg::WidthA-1:1]};
         b = {^(b & tlmsc_pkg::TapsB), b[tlmsc_pkg::WidthB-1:1]};
         c = {^(c & tlmsc_pkg::TapsC), c[tlmsc_pkg::WidthC-1:1]};
      end
      shift_a_in = a;
      shift_b_in = b;
      shift_c_in = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_a_ff <= tlmsc_pkg::SeedAReset;
         shift_b_ff <= tlmsc_pkg::SeedBReset;
         shift_c_ff <= tlmsc_pkg::SeedCReset;
      end else if (advance) begin
         shift_a_ff <= shift_a_in;
         shift_b_ff <= shift_b_in;
         shift_c_ff <= shift_c_in;
      end
   end

endmodule

// ----- design/three_lfsr_majority_stream_cipher.sv -----
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_data_in[7:0], req_restart
// rsp       out        rsp_valid / rsp_ready     rsp_data_out[7:0], rsp_key_byte[7:0]
// csr       in         APB, csr_pready tied high seed_a, seed_b, seed_c at 0x0, 0x4, 0x8
//
// A request is captured in an input register and its result is written into
// the output register once that register is free; rsp_valid is the output
// register's valid bit. One request per cycle is sustained while rsp_ready
// stays high; the eight register steps of a byte are computed in one pass
// between the two registers.
// Reset loads the seeds and the three shift registers with their defaults.
// A stalled rsp_ready holds the output register, and the input register
// takes one more request before req_ready drops.
module three_lfsr_majority_stream_cipher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_in,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_data_out,
   output logic [7:0]                            rsp_key_byte,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tlmsc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [tlmsc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [tlmsc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   tlmsc_pkg::seed_type seeds;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_restart_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff;
   logic [7:0] out_key_ff;
   logic [7:0] key_byte;
   logic       out_free;
   logic       advance;
   logic       capture;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign capture   = req_valid && req_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_key_byte = out_key_ff;

   tlmsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seeds       (seeds)
   );

   tlmsc_keygen u_keygen (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .restart  (in_restart_ff),
      .seeds    (seeds),
      .key_byte (key_byte)
   );

   always_comb begin
      in_valid_in = capture || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         in_data_ff    <= req_data_in;
         in_restart_ff <= req_restart;
      end
      if (advance) begin
         out_data_ff <= in_data_ff ^ key_byte;
         out_key_ff  <= key_byte;
      end
   end

endmodule
